@@ src/pmer_pkg.sv @@
// Shared types, constants and error-probability table for the phred mean error rate unit.
`default_nettype none
package pmer_pkg;

  localparam int LEN_BITS  = 16;
  localparam int FRAC_BITS = 31;
  localparam int SUM_W     = 48;
  localparam int ROM_W     = FRAC_BITS + 1;
  localparam int MEAN_W    = 32;
  localparam int CHAR_W    = 8;
  localparam int OFFSET_W  = 7;
  localparam int STATUS_W  = 2;
  localparam int ROM_DEPTH = 256;
  localparam int STEP_W    = $clog2(SUM_W);

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(33);
  localparam logic [CHAR_W-1:0]   MAX_CODE     = CHAR_W'(126);

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;
  localparam logic [63:0] TENTH_DECADES [10] = '{
    64'd1000000000000000000,
    64'd794328234724281502,
    64'd630957344480193249,
    64'd501187233627272285,
    64'd398107170553497250,
    64'd316227766016837933,
    64'd251188643150958011,
    64'd199526231496887960,
    64'd158489319246111348,
    64'd125892541179416721
  };

  typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_t;

  typedef struct packed {
    logic acc;
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  // 10^(-q/10) rounded half up to FRAC_BITS fraction bits
  function automatic rom_t build_rom();
    rom_t         rom;
    logic [63:0]  quo;
    logic [63:0]  rem;
    logic [63:0]  den;
    logic [63:0]  g;
    logic [64:0]  part;
    int           q;
    int           k;
    int           r;
    int           i;
    k = 0;
    r = 0;
    for (q = 0; q < ROM_DEPTH; q++) begin
      quo = (TENTH_DECADES[r] >= DEC_ONE) ? 64'd1 : 64'd0;
      rem = TENTH_DECADES[r] - ((quo != 64'd0) ? DEC_ONE : 64'd0);
      for (i = 0; i < 63; i++) begin
        quo = quo << 1;
        rem = rem << 1;
        if (rem >= DEC_ONE) begin
          rem = rem - DEC_ONE;
          quo = quo | 64'd1;
        end
      end
      g = 64'd0;
      if (k < 20) begin
        den = 64'd1;
        for (i = 0; i < k; i++) begin
          den = den * 64'd10;
        end
        part = '0;
        for (i = 63; i >= 0; i--) begin
          part = {part[63:0], quo[i]};
          if (part >= {1'b0, den}) begin
            part = part - {1'b0, den};
            g[i] = 1'b1;
          end
        end
      end
      rom[q] = ROM_W'((g + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
      if (r == 9) begin
        r = 0;
        k++;
      end else begin
        r++;
      end
    end
    return rom;
  endfunction

  localparam rom_t PHRED_ROM = build_rom();

endpackage
`default_nettype wire

@@ src/pmer_datapath.sv @@
// Accumulator, shift-subtract divider and result register of the phred mean error rate unit.
`default_nettype none
module pmer_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pmer_pkg::cmd_t                 cmd,
  input  logic                           cfg_valid,
  input  logic [pmer_pkg::OFFSET_W-1:0]  cfg_data,
  input  logic [pmer_pkg::CHAR_W-1:0]    qual_char,
  output logic [pmer_pkg::MEAN_W-1:0]    mean_error_rate,
  output logic [pmer_pkg::STATUS_W-1:0]  status
);
  import pmer_pkg::*;

  logic [OFFSET_W-1:0] char_offset;
  logic [SUM_W-1:0]    error_sum;
  logic [LEN_BITS-1:0] char_count;
  logic                bad_char_seen;
  logic                length_overflow;

  logic [SUM_W-1:0]    div_quot;
  logic [LEN_BITS-1:0] div_rem;
  logic [LEN_BITS-1:0] div_den;
  logic [STATUS_W-1:0] div_status;

  logic [CHAR_W-1:0]   score;
  logic [CHAR_W-1:0]   limit;
  logic                at_max;
  logic                add_en;
  logic [ROM_W-1:0]    rom_val;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    error_sum_next;
  logic [LEN_BITS-1:0] char_count_next;
  logic                bad_char_seen_next;
  logic                length_overflow_next;
  logic [STATUS_W-1:0] status_next;
  logic [LEN_BITS:0]   rem_sh;
  logic                rem_ge;
  logic [LEN_BITS:0]   rem_sub;
  logic [MEAN_W-1:0]   mean_sat;

  always_comb begin
    score   = qual_char - {1'b0, char_offset};
    limit   = MAX_CODE - {1'b0, char_offset};
    at_max  = (char_count == '1);
    add_en  = !at_max && (score <= limit);
    rom_val = PHRED_ROM[score];
    sum_add = {1'b0, error_sum} + (SUM_W+1)'(rom_val);

    error_sum_next = error_sum;
    if (add_en) begin
      error_sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
    char_count_next      = at_max ? char_count : char_count + LEN_BITS'(1);
    bad_char_seen_next   = bad_char_seen | (!at_max && (score > limit));
    length_overflow_next = length_overflow | at_max;

    if (bad_char_seen_next) begin
      status_next = STATUS_BAD_CHAR;
    end else if (length_overflow_next) begin
      status_next = STATUS_TOO_LONG;
    end else begin
      status_next = STATUS_OK;
    end

    rem_sh  = {div_rem, div_quot[SUM_W-1]};
    rem_ge  = (rem_sh >= {1'b0, div_den});
    rem_sub = rem_sh - {1'b0, div_den};

    if (|div_quot[SUM_W-1:MEAN_W]) begin
      mean_sat = '1;
    end else begin
      mean_sat = div_quot[MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_offset     <= OFFSET_RESET;
      error_sum       <= '0;
      char_count      <= '0;
      bad_char_seen   <= 1'b0;
      length_overflow <= 1'b0;
    end else begin
      if (cfg_valid) begin
        char_offset <= cfg_data;
      end
      if (cmd.load) begin
        error_sum       <= '0;
        char_count      <= '0;
        bad_char_seen   <= 1'b0;
        length_overflow <= 1'b0;
      end else if (cmd.acc) begin
        error_sum       <= error_sum_next;
        char_count      <= char_count_next;
        bad_char_seen   <= bad_char_seen_next;
        length_overflow <= length_overflow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_quot   <= error_sum_next;
      div_den    <= char_count_next;
      div_rem    <= '0;
      div_status <= status_next;
    end else if (cmd.step) begin
      div_quot <= {div_quot[SUM_W-2:0], rem_ge};
      div_rem  <= rem_ge ? rem_sub[LEN_BITS-1:0] : rem_sh[LEN_BITS-1:0];
    end
    if (cmd.out_load) begin
      status          <= div_status;
      mean_error_rate <= (div_status == STATUS_OK) ? mean_sat : '0;
    end
  end

endmodule
`default_nettype wire

@@ src/pmer_ctrl.sv @@
// Controller for read acceptance, divider sequencing and result handshake.
`default_nettype none
module pmer_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  input  logic           s_axis_tlast,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output pmer_pkg::cmd_t cmd
);
  import pmer_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;
  logic              out_valid;
  logic              out_valid_next;

  always_comb begin
    s_axis_tready = !s_axis_tlast || (state == S_IDLE);
    cmd.acc       = s_axis_tvalid && s_axis_tready;
    cmd.load      = cmd.acc && s_axis_tlast;
    cmd.step      = 1'b0;
    cmd.out_load  = 1'b0;
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next    = S_DIV;
          step_cnt_next = '0;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_W'(SUM_W - 1)) begin
          state_next = S_DONE;
        end else begin
          step_cnt_next = step_cnt + STEP_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load ? 1'b1 : (out_valid && !m_axis_tready);
  end

  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE)
    else $error("read closed while divider busy");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step_cnt == STEP_W'(SUM_W - 1)) |=> state == S_DONE)
    else $error("divider did not finish after last step");

  a_out_load_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == S_DONE && (!out_valid || m_axis_tready)))
    else $error("result register overwritten");

  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s_axis_tlast && state != S_IDLE))
    else $error("input stalled without pending division");

endmodule
`default_nettype wire

@@ src/phred_mean_error_rate_unit.sv @@
// Top level of the phred mean error rate unit.
//
//  group     dir  handshake                      word
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: qual_char; tlast: last
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: mean_error_rate; tuser: status
//  cfg       in   cfg_valid/cfg_ready            cfg_data: offset
//
//  Characters are taken one per cycle; the table lookup and saturating add are combinational.
//  A closed read goes to a shift-subtract divider of 48 quotient bits, then loads the result.
//  A last character is held while the previous read is dividing or waiting to load its
//  result, so a read can stall on its last word. Other characters flow on.
//  Reset (rst, synchronous) clears the read state and sets the offset to 33.
//  The result register holds until m_axis_tready; cfg_ready is always high.
`default_nettype none
module phred_mean_error_rate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pmer_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] qual_char
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pmer_pkg::MEAN_W-1:0]    m_axis_tdata,   // [31:0] mean_error_rate
  output logic [pmer_pkg::STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmer_pkg::OFFSET_W-1:0]  cfg_data
);
  import pmer_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  pmer_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  pmer_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .qual_char       (s_axis_tdata),
    .mean_error_rate (m_axis_tdata),
    .status          (m_axis_tuser)
  );

endmodule
`default_nettype wire

@@ tb/phred_mean_monitor.sv @@
// Monitor that predicts each read's mean error rate and status and compares them with the unit's results.
module phred_mean_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  input  logic                           char_ready,
  input  logic [pmer_pkg::CHAR_W-1:0]    char_data,
  input  logic                           char_last,
  input  logic                           mean_valid,
  input  logic                           mean_ready,
  input  logic [pmer_pkg::MEAN_W-1:0]    mean_data,
  input  logic [pmer_pkg::STATUS_W-1:0]  mean_status,
  input  logic                           offset_valid,
  input  logic                           offset_ready,
  input  logic [pmer_pkg::OFFSET_W-1:0]  offset_data,
  output int                             errors,
  output int                             pending
);
  import pmer_pkg::*;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [STATUS_W-1:0] status;
  } read_result_t;

  localparam logic [63:0] UNIT_E18 = 64'd1000000000000000000;
  localparam logic [63:0] TENTH_POWERS [10] = '{
    64'd1000000000000000000,
    64'd794328234724281502,
    64'd630957344480193249,
    64'd501187233627272285,
    64'd398107170553497250,
    64'd316227766016837933,
    64'd251188643150958011,
    64'd199526231496887960,
    64'd158489319246111348,
    64'd125892541179416721
  };

  logic [ROM_W-1:0]    prob_rom [ROM_DEPTH];
  read_result_t        mean_results_q [$];
  logic [SUM_W-1:0]    err_sum;
  logic [LEN_BITS-1:0] char_cnt;
  logic                bad_seen;
  logic                too_long;
  logic [OFFSET_W-1:0] offset;
  int                  fail_cnt = 0;

  function automatic logic [ROM_W-1:0] error_prob(int score);
    logic [127:0] scaled;
    logic [63:0]  divisor;
    logic [63:0]  g;
    int           k;
    k = score / 10;
    if (k >= 20) return '0;
    divisor = 64'd1;
    repeat (k) divisor = divisor * 64'd10;
    scaled = ({64'd0, TENTH_POWERS[score % 10]} << 63) / {64'd0, UNIT_E18};
    g = scaled[63:0] / divisor;
    return ROM_W'((g + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
  endfunction

  initial begin
    for (int q = 0; q < ROM_DEPTH; q++) prob_rom[q] = error_prob(q);
  end

  task automatic clear_read();
    err_sum  = '0;
    char_cnt = '0;
    bad_seen = 1'b0;
    too_long = 1'b0;
  endtask

  task automatic take_char(logic [CHAR_W-1:0] ch, logic lst);
    logic [CHAR_W-1:0] score;
    logic [CHAR_W-1:0] limit;
    logic [SUM_W:0]    total;
    logic [SUM_W-1:0]  quot;
    read_result_t      res;
    score = ch - CHAR_W'(offset);
    limit = MAX_CODE - CHAR_W'(offset);
    if (char_cnt == '1) begin
      too_long = 1'b1;
    end else begin
      char_cnt = char_cnt + LEN_BITS'(1);
      if (score > limit) begin
        bad_seen = 1'b1;
      end else begin
        total   = {1'b0, err_sum} + (SUM_W+1)'(prob_rom[score]);
        err_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
      end
    end
    if (lst) begin
      res.mean   = '0;
      res.status = STATUS_OK;
      if (bad_seen) begin
        res.status = STATUS_BAD_CHAR;
      end else if (too_long) begin
        res.status = STATUS_TOO_LONG;
      end else begin
        quot     = err_sum / SUM_W'(char_cnt);
        res.mean = (quot > SUM_W'({MEAN_W{1'b1}})) ? '1 : quot[MEAN_W-1:0];
      end
      mean_results_q.push_back(res);
      clear_read();
    end
  endtask

  task automatic check_mean(logic [MEAN_W-1:0] mean, logic [STATUS_W-1:0] status);
    read_result_t want;
    if (mean_results_q.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result: expected none, actual mean=%h status=%0d",
               $time, mean, status);
    end else begin
      want = mean_results_q.pop_front();
      if (want.mean !== mean) begin
        fail_cnt++;
        $display("%0t: mean_error_rate mismatch: expected %h, actual %h",
                 $time, want.mean, mean);
      end
      if (want.status !== status) begin
        fail_cnt++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      offset = OFFSET_RESET;
      clear_read();
      mean_results_q.delete();
    end else begin
      if (char_valid && char_ready) take_char(char_data, char_last);
      if (offset_valid && offset_ready) offset = offset_data;
      if (mean_valid && mean_ready) check_mean(mean_data, mean_status);
    end
    pending <= mean_results_q.size();
    errors  <= fail_cnt;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives quality characters, offset writes and result back-pressure, gives the verdict.
module tb;
  import pmer_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_CHARS   = 215;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CHAR_W-1:0]   s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MEAN_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data      = '0;

  int                  errors;
  int                  pending;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_requests  = 0;
  int                  hold_served    = 0;
  int                  hold_left      = 0;
  logic [OFFSET_W-1:0] cur_offset     = OFFSET_RESET;

  phred_mean_error_rate_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  phred_mean_monitor mean_mon (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (s_axis_tvalid),
    .char_ready   (s_axis_tready),
    .char_data    (s_axis_tdata),
    .char_last    (s_axis_tlast),
    .mean_valid   (m_axis_tvalid),
    .mean_ready   (m_axis_tready),
    .mean_data    (m_axis_tdata),
    .mean_status  (m_axis_tuser),
    .offset_valid (cfg_valid),
    .offset_ready (cfg_ready),
    .offset_data  (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] valid_char();
    logic [CHAR_W-1:0] limit;
    limit = MAX_CODE - CHAR_W'(cur_offset);
    return CHAR_W'(cur_offset) + CHAR_W'($urandom_range(limit));
  endfunction

  task automatic send_char(logic [CHAR_W-1:0] ch, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_read(int len, int noise_pct);
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(99) < noise_pct) ? CHAR_W'($urandom_range(255)) : valid_char();
      send_char(ch, i == len - 1);
    end
  endtask

  // drop valid and wait until every pending result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(logic [OFFSET_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_offset = value;
  endtask

  task automatic run_phase(logic [OFFSET_W-1:0] value, int idle, int stall, logic with_hold);
    int sent;
    int pick;
    int len;
    drain();
    write_offset(value);
    send_idle_pct = idle;
    recv_stall_pct <= stall;
    sent = 0;
    if (with_hold) begin
      hold_requests <= hold_requests + 1;
      repeat (30) send_read(2, 0);
      sent = 60;
    end
    while (sent < PHASE_CHARS) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        len = $urandom_range(8, 1);
        send_read(len, 100);
      end else if (pick < 20) begin
        len = $urandom_range(12, 1);
        send_read(len, 25);
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(16, 1) : $urandom_range(90, 17);
        send_read(len, 0);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset offset: extremes and invalid characters
    send_char(8'd33, 1'b1);
    send_char(8'd126, 1'b1);
    send_char(8'd127, 1'b1);
    send_char(8'd0, 1'b1);
    send_char(8'd255, 1'b1);
    send_char(8'd60, 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd40, 1'b1);

    drain();
    write_offset(7'd127);
    send_char(8'd0, 1'b1);
    send_char(8'd255, 1'b1);
    send_char(8'd127, 1'b0);
    send_char(8'd126, 1'b1);

    drain();
    write_offset(7'd0);
    send_char(8'd0, 1'b1);
    send_char(8'd126, 1'b1);
    send_char(8'd127, 1'b1);

    drain();
    write_offset(7'd126);
    send_char(8'd126, 1'b1);
    send_char(8'd125, 1'b1);
    send_char(8'd127, 1'b1);

    run_phase(OFFSET_RESET, 0, 0, 1'b1);
    run_phase(7'd127, 53, 0, 1'b0);
    run_phase(7'd0, 0, 53, 1'b0);
    run_phase(OFFSET_W'($urandom_range(125, 1)), 18, 18, 1'b0);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ phred_mean_error_rate_unit.f @@
src/pmer_pkg.sv
src/pmer_datapath.sv
src/pmer_ctrl.sv
src/phred_mean_error_rate_unit.sv
tb/phred_mean_monitor.sv
tb/tb.sv
